// ===== hw/rtl/mbps_pkg.sv =====
// Shared types and constants for the masked byte pattern scanner.
package mbps_pkg;

    localparam int BYTE_W          = 8;
    localparam int OFFSET_W        = 32;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_ADDR_W      = 2;
    localparam int MASK_W          = 16;
    localparam int LEN_CFG_W       = 5;
    localparam int PATTERN_MAX_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PAT_LOW  = 2'd0,
        CFG_PAT_HIGH = 2'd1,
        CFG_WILDCARD = 2'd2,
        CFG_LENGTH   = 2'd3
    } cfg_idx_t;

    // Per-cell compare selection: expected byte and whether it must match
    typedef struct packed {
        logic [BYTE_W-1:0] pat;
        logic              care;
    } cell_sel_t;

endpackage

// ===== hw/rtl/mbps_cell.sv =====
// One window cell: holds a history byte, passes it on, compares its tap.
module mbps_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          clear,
    input  logic [mbps_pkg::BYTE_W-1:0]   byte_in,
    input  mbps_pkg::cell_sel_t           sel,
    output logic [mbps_pkg::BYTE_W-1:0]   byte_out,
    output logic                          hit
);
    import mbps_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    always_comb
    begin
        priority if (clear)
        begin
            byte_next = '0;
        end
        else if (advance)
        begin
            byte_next = byte_in;
        end
        else
        begin
            byte_next = byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;
    assign hit      = !sel.care || (byte_in == sel.pat);

endmodule

// ===== hw/rtl/masked_byte_pattern_scanner.sv =====
// Top level of the masked byte pattern scanner: cell chain, counter, result register.
//
// Usage: bytes of a region arrive on the s_ stream, one per request, with
// s_tlast on the region's last byte. A pattern of 1 to PATTERN_MAX bytes is
// loaded through the cfg_ write port (pattern bytes low/high, wildcard mask,
// length) while the scanner is idle; a set wildcard bit matches any byte.
// Each region yields exactly one result request on the m_ stream: at the first
// byte that completes a match (m_tuser found = 1, m_tdata = start offset), or
// at the region's last byte with found = 0 and offset 0 if nothing matched.
// Bytes after a match produce nothing until the region ends.
// The result is registered: on m_ in the cycle after the byte that causes it.
// Throughput: one byte per cycle; every window cell compares its tap in the
// same cycle, so the whole match decision fits in the cycle that takes the byte.
// Stall: the result register holds while m_tready is low; s_tready then drops
// only while a result is held and not taken, so bytes flow while m_ is free.
// Reset: the window, offset counter and found flag clear; the pattern clears,
// the wildcard mask clears and the length returns to one.
module masked_byte_pattern_scanner #(
    parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [mbps_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Byte stream in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mbps_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] data_byte
    input  logic                              s_tlast,   // region_end
    // Result stream out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mbps_pkg::OFFSET_W-1:0]     m_tdata,   // [31:0] match_offset
    output logic [0:0]                        m_tuser    // [0] found
);
    import mbps_pkg::*;

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    // Configuration registers
    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;
    logic [MASK_W-1:0]     wild_reg;
    logic [LEN_CFG_W-1:0]  len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            wild_reg     <= '0;
            len_reg      <= LEN_CFG_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_PAT_LOW:  pat_low_reg  <= cfg_data;
                CFG_PAT_HIGH: pat_high_reg <= cfg_data;
                CFG_WILDCARD: wild_reg     <= cfg_data[MASK_W-1:0];
                CFG_LENGTH:   len_reg      <= cfg_data[LEN_CFG_W-1:0];
                default:      ;
            endcase
        end
    end

    // Clamp the length into 1..PATTERN_MAX
    logic [LEN_W-1:0] len_used;

    always_comb
    begin
        priority if (len_reg == '0)
        begin
            len_used = LEN_W'(1);
        end
        else if (len_reg > LEN_CFG_W'(PATTERN_MAX))
        begin
            len_used = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            len_used = len_reg[LEN_W-1:0];
        end
    end

    // Pattern bytes as an array
    logic [2*CFG_DATA_W-1:0]              pat_all;
    logic [PATTERN_MAX-1:0][BYTE_W-1:0]   pat_bytes;
    logic [PATTERN_MAX-1:0]               mask_vec;

    assign pat_all  = {pat_high_reg, pat_low_reg};
    assign mask_vec = wild_reg[PATTERN_MAX-1:0];

    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            pat_bytes[i] = pat_all[i*BYTE_W +: BYTE_W];
        end
    end

    // Handshake
    logic s_acc;
    logic region_clear;
    logic res_valid_reg;
    logic res_valid_next;
    logic res_found_reg;
    logic res_found_next;
    logic [OFFSET_W-1:0] res_off_reg;
    logic [OFFSET_W-1:0] res_off_next;

    assign s_tready     = !res_valid_reg || m_tready;
    assign s_acc        = s_tvalid && s_tready;
    assign region_clear = s_acc && s_tlast;

    // Cell chain: cell k sees the byte taken k requests ago (cell 0 the new one)
    logic [BYTE_W-1:0]      tap [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] cell_hit;
    cell_sel_t              cell_sel [PATTERN_MAX];

    assign tap[0] = s_tdata;

    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cell
        logic [IDX_W-1:0] idx;

        // Newest byte lines up with the last pattern byte
        assign idx = IDX_W'(len_used - LEN_W'(k) - LEN_W'(1));

        always_comb
        begin
            cell_sel[k].pat  = pat_bytes[idx];
            cell_sel[k].care = (LEN_W'(k) < len_used) && !mask_vec[idx];
        end

        if (k < PATTERN_MAX - 1)
        begin : g_pass
            mbps_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (s_acc),
                .clear    (region_clear),
                .byte_in  (tap[k]),
                .sel      (cell_sel[k]),
                .byte_out (tap[k+1]),
                .hit      (cell_hit[k])
            );
        end
        else
        begin : g_end
            mbps_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (s_acc),
                .clear    (region_clear),
                .byte_in  (tap[k]),
                .sel      (cell_sel[k]),
                .byte_out (),
                .hit      (cell_hit[k])
            );
        end
    end

    // Offset counter and found flag
    logic [OFFSET_BITS-1:0] count_reg;
    logic [OFFSET_BITS-1:0] count_next;
    logic                   done_reg;
    logic                   done_next;
    logic [OFFSET_BITS-1:0] len_less1;
    logic [OFFSET_BITS-1:0] start_off;
    logic                   match_now;
    logic                   miss_end;

    assign len_less1 = OFFSET_BITS'(len_used - LEN_W'(1));
    assign start_off = count_reg - len_less1;
    assign match_now = !done_reg && (count_reg >= len_less1) && (&cell_hit);
    assign miss_end  = !done_reg && !match_now && s_tlast;

    always_comb
    begin
        count_next = count_reg;
        done_next  = done_reg;
        if (s_acc)
        begin
            priority if (s_tlast)
            begin
                count_next = '0;
                done_next  = 1'b0;
            end
            else
            begin
                if (count_reg != '1)
                begin
                    count_next = count_reg + OFFSET_BITS'(1);
                end
                done_next = done_reg || match_now;
            end
        end
    end

    // Result register: load on an emitting byte, drain when taken
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_found_next = res_found_reg;
        res_off_next   = res_off_reg;
        priority if (s_acc && (match_now || miss_end))
        begin
            res_valid_next = 1'b1;
            res_found_next = match_now;
            res_off_next   = match_now ? OFFSET_W'(start_off) : '0;
        end
        else if (m_tready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            done_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            done_reg      <= done_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_found_reg <= res_found_next;
        res_off_reg   <= res_off_next;
    end

    assign m_tvalid   = res_valid_reg;
    assign m_tdata    = res_off_reg;
    assign m_tuser[0] = res_found_reg;

    // Checks
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        region_clear |=> (count_reg == '0) && !done_reg)
        else $error("region end did not clear counter and found flag");

    a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (region_clear && !done_reg) |=> m_tvalid)
        else $error("region ended without a result");

    a_match_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && !s_tlast && match_now) |=> done_reg && m_tvalid && m_tuser[0])
        else $error("match not reported or not latched");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

endmodule
